// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; included by the checker only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed (same-cycle implication)");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed (next-cycle implication)");

`endif

// ===== hdl/bpic_pkg.sv =====
// Package for the bellows pressure integral controller: widths, register
// indexes, reset values, payload structs and the lane control struct. No dependencies.
package bpic_pkg;

  localparam int CHANNELS     = 6;
  localparam int SECTION_SIZE = 3;
  localparam int SECTIONS     = 2;

  localparam int READING_BITS  = 12;
  localparam int PRESSURE_BITS = 16;
  localparam int TARGET_BITS   = 12;
  localparam int GAIN_BITS     = 8;
  localparam int TOL_BITS      = 12;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 12;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_0        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_1        = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_2        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_3        = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_4        = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_5        = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_GAIN       = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ERROR_TOLERANCE = 3'd7;

  localparam logic [TARGET_BITS-1:0] TARGET_RESET [CHANNELS] =
    '{12'd2422, 12'd2142, 12'd2182, 12'd3263, 12'd3363, 12'd3704};
  localparam logic [GAIN_BITS-1:0] STEP_GAIN_RESET = 8'd128;
  localparam logic [TOL_BITS-1:0]  TOL_RESET       = 12'd82;

  // Datapath widths, all derived from the field widths above.
  localparam int ERR_BITS =
    (READING_BITS > TARGET_BITS ? READING_BITS : TARGET_BITS) + 1;
  localparam int COMB_BITS = ERR_BITS + 2;
  localparam int PROD_BITS = COMB_BITS + GAIN_BITS + 1;
  localparam int INC_SHIFT = READING_BITS + GAIN_BITS - (PRESSURE_BITS - 4);
  localparam int INC_BITS  =
    (INC_SHIFT > 0) ? PROD_BITS + 1 - INC_SHIFT : PROD_BITS - INC_SHIFT;
  localparam int NEXT_BITS =
    (PRESSURE_BITS > INC_BITS ? PRESSURE_BITS : INC_BITS) + 1;
  localparam int SUM_BITS      = NEXT_BITS + 2;
  localparam int MEAN_IN_BITS  = SUM_BITS + 1;
  localparam int DIV_BITS      = MEAN_IN_BITS + 1;
  localparam int DIV_K         = DIV_BITS + 1;
  localparam int DIV_MULT_BITS = DIV_K - 1;
  localparam int DIV_PROD_BITS = DIV_BITS + DIV_MULT_BITS;
  localparam int DIFF_BITS     = MEAN_IN_BITS + 1;

  // Floor division by three: bias to a non-negative value, then multiply
  // by the rounded-up reciprocal.
  localparam logic [63:0] DIV_BIAS = 64'd3 << (MEAN_IN_BITS - 1);
  localparam logic [63:0] DIV_MULT = ((64'd1 << DIV_K) + 64'd2) / 64'd3;

  typedef struct packed {
    logic [READING_BITS-1:0] reading_0;
    logic [READING_BITS-1:0] reading_1;
    logic [READING_BITS-1:0] reading_2;
    logic [READING_BITS-1:0] reading_3;
    logic [READING_BITS-1:0] reading_4;
    logic [READING_BITS-1:0] reading_5;
    logic                    gripper_request;
  } in_item_t;

  typedef struct packed {
    logic signed [PRESSURE_BITS-1:0] pressure_0;
    logic signed [PRESSURE_BITS-1:0] pressure_1;
    logic signed [PRESSURE_BITS-1:0] pressure_2;
    logic signed [PRESSURE_BITS-1:0] pressure_3;
    logic signed [PRESSURE_BITS-1:0] pressure_4;
    logic signed [PRESSURE_BITS-1:0] pressure_5;
    logic                            all_in_tolerance;
    logic                            gripper_valve;
  } out_item_t;

  typedef struct packed {
    logic                 load;
    logic [GAIN_BITS-1:0] step_gain;
    logic [TOL_BITS-1:0]  error_tolerance;
  } lane_ctl_t;

endpackage

// ===== hdl/bpic_lane.sv =====
// One channel lane: error, tolerance test and scaled integrator increment.
// Depends on bpic_pkg.
module bpic_lane (
  input  logic                                     clk,
  input  bpic_pkg::lane_ctl_t                      ctl,
  input  logic        [bpic_pkg::TARGET_BITS-1:0]  target,
  input  logic        [bpic_pkg::READING_BITS-1:0] reading,
  input  logic signed [bpic_pkg::ERR_BITS-1:0]     err_a,
  input  logic signed [bpic_pkg::ERR_BITS-1:0]     err_b,
  output logic signed [bpic_pkg::ERR_BITS-1:0]     err,
  output logic signed [bpic_pkg::INC_BITS-1:0]     inc,
  output logic                                     ok
);
  import bpic_pkg::*;

  logic        [ERR_BITS-1:0]  mag;
  logic                        ok_c;
  logic signed [COMB_BITS-1:0] comb;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [INC_BITS-1:0]  inc_c;

  assign err  = ERR_BITS'($signed({1'b0, target})) - ERR_BITS'($signed({1'b0, reading}));
  assign mag  = err[ERR_BITS-1] ? ERR_BITS'(-err) : ERR_BITS'(err);
  assign ok_c = mag < ERR_BITS'(ctl.error_tolerance);

  assign comb = COMB_BITS'(err) - COMB_BITS'(err_a) - COMB_BITS'(err_b);
  assign prod = PROD_BITS'(comb) * PROD_BITS'($signed({1'b0, ctl.step_gain}));

  generate
    if (INC_SHIFT > 0) begin : g_round
      // Round to nearest, ties toward plus infinity, by adding half an LSB
      // and shifting arithmetically.
      localparam logic [PROD_BITS:0] ROUND_HALF =
        (PROD_BITS + 1)'(64'd1 << (INC_SHIFT - 1));
      logic signed [PROD_BITS:0] rnd;
      assign rnd   = (PROD_BITS + 1)'(prod) + $signed(ROUND_HALF);
      assign inc_c = INC_BITS'(rnd >>> INC_SHIFT);
    end else begin : g_widen
      assign inc_c = INC_BITS'(prod) <<< (-INC_SHIFT);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      inc <= inc_c;
      ok  <= ok_c;
    end
  end

endmodule

// ===== hdl/bpic_section.sv =====
// Section merge: integrates three increments, removes the section mean and
// saturates. Holds the section's pressure state. Depends on bpic_pkg.
module bpic_section (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      update,
  input  logic signed [bpic_pkg::INC_BITS-1:0]      inc [bpic_pkg::SECTION_SIZE],
  output logic signed [bpic_pkg::PRESSURE_BITS-1:0] level [bpic_pkg::SECTION_SIZE]
);
  import bpic_pkg::*;

  localparam logic signed [DIFF_BITS-1:0] P_MAX =
    DIFF_BITS'((64'sd1 <<< (PRESSURE_BITS - 1)) - 64'sd1);
  localparam logic signed [DIFF_BITS-1:0] P_MIN = -P_MAX - 1;

  logic signed [PRESSURE_BITS-1:0] pressure      [SECTION_SIZE];
  logic signed [PRESSURE_BITS-1:0] pressure_next [SECTION_SIZE];
  logic signed [NEXT_BITS-1:0]     nxt           [SECTION_SIZE];
  logic signed [DIFF_BITS-1:0]     diff          [SECTION_SIZE];
  logic signed [SUM_BITS-1:0]      sum;
  logic signed [MEAN_IN_BITS-1:0]  mean_in;
  logic        [DIV_BITS-1:0]      biased;
  logic        [DIV_PROD_BITS-1:0] div_prod;
  logic        [MEAN_IN_BITS-1:0]  quot;
  logic signed [MEAN_IN_BITS-1:0]  mean;

  always_comb begin
    sum = '0;
    for (int k = 0; k < SECTION_SIZE; k++) begin
      nxt[k] = NEXT_BITS'(pressure[k]) + NEXT_BITS'(inc[k]);
      sum    = sum + SUM_BITS'(nxt[k]);
    end
    // The rounded mean floor((2*sum + 3) / 6) equals floor((sum + 1) / 3).
    mean_in  = MEAN_IN_BITS'(sum) + MEAN_IN_BITS'(1);
    biased   = DIV_BITS'(mean_in) + DIV_BITS'(DIV_BIAS);
    div_prod = DIV_PROD_BITS'(biased) * DIV_PROD_BITS'(DIV_MULT);
    quot     = div_prod[DIV_PROD_BITS-1:DIV_K];
    // Removing the bias is a flip of the top bit.
    mean     = $signed({~quot[MEAN_IN_BITS-1], quot[MEAN_IN_BITS-2:0]});
    for (int k = 0; k < SECTION_SIZE; k++) begin
      diff[k] = DIFF_BITS'(nxt[k]) - DIFF_BITS'(mean);
      if (diff[k] > P_MAX) begin
        pressure_next[k] = PRESSURE_BITS'(P_MAX);
      end else if (diff[k] < P_MIN) begin
        pressure_next[k] = PRESSURE_BITS'(P_MIN);
      end else begin
        pressure_next[k] = PRESSURE_BITS'(diff[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure <= '{default: '0};
    end else if (update) begin
      pressure <= pressure_next;
    end
  end

  assign level = pressure;

endmodule

// ===== hdl/bellows_pressure_integral_control_core.sv =====
// Top level of the bellows pressure integral controller: configuration
// registers, six lanes, two section merges and the output handshake.
// Depends on bpic_pkg, bpic_lane and bpic_section.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries six readings and the
//   gripper request. Output channel out_valid / out_stall / out_data carries
//   six pressures, the in-tolerance flag and the gripper valve drive. A
//   transfer happens on a rising edge with valid high and stall low.
//   Configuration writes use cfg_valid / cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write only while no item is in flight.
//   A result passes through the lane registers, then the pressure and output registers.
//   Throughput: one item per cycle while the receiver does not stall. The lanes
//   register the scaled increments; the section update (sum, divide by three by
//   reciprocal multiply, saturate) is combinational into the pressure registers.
//   Reset loads the default targets, gain and tolerance and clears all
//   pressures. While the receiver stalls, the result holds, one further item
//   is taken into the lane registers, and then in_stall rises.
module bellows_pressure_integral_control_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  bpic_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output bpic_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bpic_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [bpic_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import bpic_pkg::*;

  logic [TARGET_BITS-1:0]  target [CHANNELS];
  logic [GAIN_BITS-1:0]    step_gain;
  logic [TOL_BITS-1:0]     error_tolerance;

  logic                    s1_valid;
  logic                    s1_grip;
  logic                    out_ok;
  logic                    out_grip;
  logic                    advance;
  logic                    load;
  lane_ctl_t               lane_ctl;

  logic        [READING_BITS-1:0]  reading [CHANNELS];
  logic signed [ERR_BITS-1:0]      err     [CHANNELS];
  logic signed [INC_BITS-1:0]      inc     [CHANNELS];
  logic        [CHANNELS-1:0]      lane_ok;
  logic signed [PRESSURE_BITS-1:0] level   [CHANNELS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target          <= TARGET_RESET;
      step_gain       <= STEP_GAIN_RESET;
      error_tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_0, REG_TARGET_1, REG_TARGET_2,
        REG_TARGET_3, REG_TARGET_4, REG_TARGET_5: begin
          target[cfg_index] <= cfg_data[TARGET_BITS-1:0];
        end
        REG_STEP_GAIN: begin
          step_gain <= cfg_data[GAIN_BITS-1:0];
        end
        REG_ERROR_TOLERANCE: begin
          error_tolerance <= cfg_data[TOL_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The section state moves only when the output register is free, so the
  // pressure registers double as the output payload.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  assign lane_ctl.load            = load;
  assign lane_ctl.step_gain       = step_gain;
  assign lane_ctl.error_tolerance = error_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_grip <= in_data.gripper_request;
    end
    if (advance) begin
      out_ok   <= &lane_ok;
      out_grip <= s1_grip;
    end
  end

  assign reading[0] = in_data.reading_0;
  assign reading[1] = in_data.reading_1;
  assign reading[2] = in_data.reading_2;
  assign reading[3] = in_data.reading_3;
  assign reading[4] = in_data.reading_4;
  assign reading[5] = in_data.reading_5;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    localparam int BASE = (ch / SECTION_SIZE) * SECTION_SIZE;
    localparam int POS  = ch % SECTION_SIZE;
    localparam int SIB_A = BASE + (POS + 1) % SECTION_SIZE;
    localparam int SIB_B = BASE + (POS + 2) % SECTION_SIZE;
    bpic_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .target  (target[ch]),
      .reading (reading[ch]),
      .err_a   (err[SIB_A]),
      .err_b   (err[SIB_B]),
      .err     (err[ch]),
      .inc     (inc[ch]),
      .ok      (lane_ok[ch])
    );
  end

  for (genvar s = 0; s < SECTIONS; s++) begin : g_section
    logic signed [INC_BITS-1:0]      sec_inc   [SECTION_SIZE];
    logic signed [PRESSURE_BITS-1:0] sec_level [SECTION_SIZE];
    for (genvar k = 0; k < SECTION_SIZE; k++) begin : g_map
      assign sec_inc[k]                    = inc[s * SECTION_SIZE + k];
      assign level[s * SECTION_SIZE + k]   = sec_level[k];
    end
    bpic_section u_section (
      .clk    (clk),
      .rst    (rst),
      .update (advance),
      .inc    (sec_inc),
      .level  (sec_level)
    );
  end

  always_comb begin
    out_data.pressure_0       = level[0];
    out_data.pressure_1       = level[1];
    out_data.pressure_2       = level[2];
    out_data.pressure_3       = level[3];
    out_data.pressure_4       = level[4];
    out_data.pressure_5       = level[5];
    out_data.all_in_tolerance = out_ok;
    out_data.gripper_valve    = out_grip;
  end

endmodule

// ===== hdl/bpic_checker.sv =====
// Port-level checker for the bellows pressure integral controller, bound to
// the top level. Depends on bpic_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpic_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input bpic_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input bpic_pkg::out_item_t out_data
);

  // A stalled result keeps its payload.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

  // A stalled input keeps its payload until it is taken.
  `ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid && $stable(in_data))

  // The input side backs up only when the output side is full and stalled.
  `ASSERT_IMPL(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // After every transfer in, out_valid is high once the item has left the lane registers.
  `ASSERT_NEXT(a_in_to_out, clk, rst, in_valid && !in_stall, ##1 out_valid)

endmodule

bind bellows_pressure_integral_control_core bpic_checker u_bpic_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for bellows_pressure_integral_control_core: drives sensor frames and
// register writes, predicts every pressure frame and compares it field by field.
// Depends on bpic_pkg and the core RTL.
module testbench;
  import bpic_pkg::*;

  localparam int GAIN_SHIFT = READING_BITS + GAIN_BITS - (PRESSURE_BITS - 4);
  localparam int ITEMS_PER_SESSION = 245;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_stall;
  out_item_t                 out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Own copy of the registers and the integrator state.
  logic [TARGET_BITS-1:0] target_reg [CHANNELS];
  logic [GAIN_BITS-1:0]   gain_reg;
  logic [TOL_BITS-1:0]    tol_reg;
  longint                 pressure_acc [CHANNELS];

  out_item_t              pending_results [$];
  logic [READING_BITS-1:0] frame [CHANNELS];
  bit                     calm_stretch;
  int                     mismatch_count;

  bellows_pressure_integral_control_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic longint floor_div6(longint n);
    longint q;
    q = n / 6;
    if (n < 0 && (n % 6) != 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_pressure(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (PRESSURE_BITS - 1)) - 1;
    lo = -(longint'(1) << (PRESSURE_BITS - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Advances the integrator by one frame and returns the expected outputs.
  function automatic out_item_t integrate_pressures(in_item_t item);
    longint    rd [CHANNELS];
    longint    err [CHANNELS];
    longint    nxt [CHANNELS];
    longint    comb;
    longint    sum;
    longint    mean;
    longint    mag;
    bit        ok;
    int        b;
    out_item_t res;
    rd[0] = item.reading_0;
    rd[1] = item.reading_1;
    rd[2] = item.reading_2;
    rd[3] = item.reading_3;
    rd[4] = item.reading_4;
    rd[5] = item.reading_5;
    ok = 1'b1;
    for (int k = 0; k < CHANNELS; k++) begin
      err[k] = longint'(target_reg[k]) - rd[k];
      mag = (err[k] < 0) ? -err[k] : err[k];
      if (!(mag < longint'(tol_reg))) ok = 1'b0;
    end
    for (int s = 0; s < SECTIONS; s++) begin
      b = s * SECTION_SIZE;
      sum = 0;
      for (int k = 0; k < SECTION_SIZE; k++) begin
        comb = err[b + k] - err[b + (k + 1) % 3] - err[b + (k + 2) % 3];
        nxt[b + k] = pressure_acc[b + k] +
          ((comb * longint'(gain_reg) + (longint'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT);
        sum = sum + nxt[b + k];
      end
      mean = floor_div6(2 * sum + 3);
      for (int k = 0; k < SECTION_SIZE; k++)
        pressure_acc[b + k] = clamp_pressure(nxt[b + k] - mean);
    end
    res.pressure_0       = pressure_acc[0][PRESSURE_BITS-1:0];
    res.pressure_1       = pressure_acc[1][PRESSURE_BITS-1:0];
    res.pressure_2       = pressure_acc[2][PRESSURE_BITS-1:0];
    res.pressure_3       = pressure_acc[3][PRESSURE_BITS-1:0];
    res.pressure_4       = pressure_acc[4][PRESSURE_BITS-1:0];
    res.pressure_5       = pressure_acc[5][PRESSURE_BITS-1:0];
    res.all_in_tolerance = ok;
    res.gripper_valve    = item.gripper_request;
    return res;
  endfunction

  function automatic logic signed [PRESSURE_BITS-1:0] pressure_of(out_item_t r, int k);
    case (k)
      0:       return r.pressure_0;
      1:       return r.pressure_1;
      2:       return r.pressure_2;
      3:       return r.pressure_3;
      4:       return r.pressure_4;
      default: return r.pressure_5;
    endcase
  endfunction

  task automatic report_mismatch(string field, logic signed [PRESSURE_BITS-1:0] expv,
                                 logic signed [PRESSURE_BITS-1:0] actv);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s at %0t: expected %0d, got %0d", field, $realtime, expv, actv);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = pending_results.pop_front();
        for (int k = 0; k < CHANNELS; k++)
          if (pressure_of(out_data, k) !== pressure_of(want, k))
            report_mismatch($sformatf("pressure_%0d", k), pressure_of(want, k),
                            pressure_of(out_data, k));
        if (out_data.all_in_tolerance !== want.all_in_tolerance)
          report_mismatch("all_in_tolerance", {15'd0, want.all_in_tolerance},
                          {15'd0, out_data.all_in_tolerance});
        if (out_data.gripper_valve !== want.gripper_valve)
          report_mismatch("gripper_valve", {15'd0, want.gripper_valve},
                          {15'd0, out_data.gripper_valve});
      end
    end
  end

  // The receiver holds off now and then in short bursts.
  initial begin : receiver_stall
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) hold--;
      else if (!calm_stretch && $urandom_range(99, 0) < 4) hold = $urandom_range(3, 1);
      out_stall <= (hold > 0);
    end
  end

  // Sends the current frame. Valid stays high on return so that the next
  // frame can follow back to back; callers that pause lower it first.
  task automatic send_frame(bit grip);
    in_item_t item;
    if (!calm_stretch && $urandom_range(99, 0) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    item.reading_0       = frame[0];
    item.reading_1       = frame[1];
    item.reading_2       = frame[2];
    item.reading_3       = frame[3];
    item.reading_4       = frame[4];
    item.reading_5       = frame[5];
    item.gripper_request = grip;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(integrate_pressures(item));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_TARGET_5) target_reg[idx] = data[TARGET_BITS-1:0];
    else if (idx == REG_STEP_GAIN) gain_reg = data[GAIN_BITS-1:0];
    else if (idx == REG_ERROR_TOLERANCE) tol_reg = data[TOL_BITS-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic frame_at_targets();
    for (int k = 0; k < CHANNELS; k++) frame[k] = target_reg[k];
  endtask

  // Errors just inside and just outside the default tolerance, both signs.
  task automatic test_tolerance_edges();
    frame_at_targets();
    send_frame(1'b1);
    frame_at_targets();
    frame[0] = target_reg[0] - 12'd81;
    send_frame(1'b0);
    frame_at_targets();
    frame[2] = target_reg[2] - 12'd82;
    send_frame(1'b1);
    frame_at_targets();
    frame[4] = target_reg[4] + 12'd81;
    send_frame(1'b0);
    frame_at_targets();
    frame[5] = target_reg[5] + 12'd82;
    send_frame(1'b1);
  endtask

  task automatic test_reading_extremes();
    for (int k = 0; k < CHANNELS; k++) frame[k] = '0;
    send_frame(1'b0);
    for (int k = 0; k < CHANNELS; k++) frame[k] = '1;
    send_frame(1'b1);
    for (int k = 0; k < CHANNELS; k++) frame[k] = 12'hAAA;
    send_frame(1'b0);
    for (int k = 0; k < CHANNELS; k++) frame[k] = 12'h555;
    send_frame(1'b1);
  endtask

  // Full-scale error on one bellows per section drives the pressures into
  // saturation; then zero gain, zero tolerance and minimal tolerance.
  task automatic test_register_extremes();
    write_reg(REG_TARGET_0, 12'hFFF);
    write_reg(REG_TARGET_1, 12'hFFF);
    write_reg(REG_TARGET_2, 12'hFFF);
    write_reg(REG_TARGET_3, 12'h000);
    write_reg(REG_TARGET_4, 12'h000);
    write_reg(REG_TARGET_5, 12'h000);
    write_reg(REG_STEP_GAIN, 12'hFFF);
    write_reg(REG_ERROR_TOLERANCE, 12'hFFF);
    repeat (8) begin
      frame_at_targets();
      frame[0] = 12'h000;
      frame[3] = 12'hFFF;
      send_frame(1'b1);
    end
    write_reg(REG_STEP_GAIN, 12'hF00);
    write_reg(REG_ERROR_TOLERANCE, 12'h000);
    frame_at_targets();
    send_frame(1'b0);
    for (int k = 0; k < CHANNELS; k++) frame[k] = 12'h7FF;
    send_frame(1'b1);
    write_reg(REG_ERROR_TOLERANCE, 12'h001);
    frame_at_targets();
    send_frame(1'b0);
  endtask

  function automatic logic [11:0] pick_extreme_or_random();
    case ($urandom_range(3, 0))
      0:       return 12'h000;
      1:       return 12'hFFF;
      default: return 12'($urandom_range(4095, 0));
    endcase
  endfunction

  task automatic randomize_registers();
    logic [CFG_DATA_BITS-1:0] data;
    for (int k = 0; k < CHANNELS; k++)
      write_reg(CFG_INDEX_BITS'(k), pick_extreme_or_random());
    case ($urandom_range(3, 0))
      0:       data = {4'($urandom_range(15, 0)), 8'h00};
      1:       data = {4'($urandom_range(15, 0)), 8'hFF};
      default: data = 12'($urandom_range(4095, 0));
    endcase
    write_reg(REG_STEP_GAIN, data);
    case ($urandom_range(7, 0))
      0:       data = 12'h000;
      1:       data = 12'hFFF;
      default: data = 12'($urandom_range(300, 1));
    endcase
    write_reg(REG_ERROR_TOLERANCE, data);
  endtask

  // Mostly readings scattered around the targets across the tolerance
  // boundary, some fully random frames, some frames exactly on target.
  task automatic build_random_frame();
    int mode;
    int spread;
    int value;
    mode = $urandom_range(99, 0);
    spread = (tol_reg > 1000) ? 1000 : int'(tol_reg) + 4;
    for (int k = 0; k < CHANNELS; k++) begin
      if (mode < 75) begin
        value = int'(target_reg[k]) + $urandom_range(2 * spread, 0) - spread;
        if (value < 0) value = 0;
        if (value > 4095) value = 4095;
        frame[k] = 12'(value);
      end else if (mode < 90) begin
        frame[k] = 12'($urandom_range(4095, 0));
      end else begin
        frame[k] = target_reg[k];
      end
    end
  endtask

  task automatic test_random_sessions();
    for (int session = 0; session < 5; session++) begin
      randomize_registers();
      calm_stretch = (session == 2);
      for (int n = 0; n < ITEMS_PER_SESSION; n++) begin
        // Let the pipeline empty completely once in the middle of a session.
        if (session == 3 && n == ITEMS_PER_SESSION / 2) wait_drained();
        build_random_frame();
        send_frame(1'($urandom_range(1, 0)));
      end
      calm_stretch = 1'b0;
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    calm_stretch   = 1'b0;
    mismatch_count = 0;
    for (int k = 0; k < CHANNELS; k++) begin
      target_reg[k]   = TARGET_RESET[k];
      pressure_acc[k] = 0;
      frame[k]        = '0;
    end
    gain_reg = STEP_GAIN_RESET;
    tol_reg  = TOL_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_tolerance_edges();
    test_reading_extremes();
    test_register_extremes();
    test_random_sessions();

    in_valid <= 1'b0;
    for (int w = 0; w < 1000 && pending_results.size() != 0; w++) @(negedge clk);
    repeat (4) @(negedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
